// ===== rtl/lkvc_pkg.sv =====
// package for the lru key-value cache
// holds default sizes, opcodes and the per-cell control struct; no dependencies
package lkvc_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 16;
    localparam int VALUE_BITS_DEF  = 16;

    localparam int              CAP_W     = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    typedef struct packed {
        logic shift;
        logic valid_we;
        logic valid_nxt;
    } t_cell_ctl;

endpackage

// ===== rtl/lkvc_cell.sv =====
// one entry of the recency-ordered cell row: key, value and valid bit
// depends on lkvc_pkg for the control struct
module lkvc_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lkvc_pkg::t_cell_ctl   i_ctl,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [KEY_BITS-1:0]   i_prev_key,
    input  logic [VALUE_BITS-1:0] i_prev_val,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_val,
    output logic                  o_valid,
    output logic                  o_match
);
    import lkvc_pkg::*;

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_key <= i_prev_key;
            r_val <= i_prev_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.valid_we) begin
            r_valid <= i_ctl.valid_nxt;
        end
    end

    assign o_key   = r_key;
    assign o_val   = r_val;
    assign o_valid = r_valid;
    assign o_match = r_valid && (r_key == i_key);

endmodule

// ===== rtl/lru_key_value_cache_top.sv =====
// top level of the lru key-value cache
// instantiates a row of lkvc_cell entries; depends on lkvc_pkg
//
// Fully associative key-value store kept in order of use: cell 0 holds the most
// recent entry, and a hit or an insert moves entries one cell down the row toward
// the least recent end. One request is taken per clock; a get returns its result
// in the cycle after its beat, a set returns nothing. The rate is set by the
// combinational broadcast compare of the key against every cell and the shift
// along the row. Accepting stalls only while a get result waits unread.
// Capacity 0 acts as 1 and values above the entry count saturate; no clearing
// pass is needed after reset.
module lru_key_value_cache_top #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_opcode,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [VALUE_BITS-1:0]        i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic signed [VALUE_BITS:0]   o_value_out
);
    import lkvc_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

    logic [CAP_W-1:0]      r_capacity;
    logic [CW-1:0]         r_fill, n_fill;
    logic                  r_out_valid, n_out_valid;
    logic                  r_hit, n_hit;
    logic [VALUE_BITS:0]   r_value_out, n_value_out;

    logic [KEY_BITS-1:0]   w_key   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] w_val   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] w_valid;
    logic [MAX_ENTRIES-1:0] w_match;
    logic [MAX_ENTRIES-1:0] w_le;
    t_cell_ctl             w_ctl   [MAX_ENTRIES];

    logic                  w_acc;
    logic                  w_hit;
    logic                  w_is_set;
    logic                  w_insert;
    logic [VALUE_BITS-1:0] w_hit_val;
    logic [VALUE_BITS-1:0] w_front_val;
    logic [CW-1:0]         w_cap;
    logic [CW-1:0]         w_fkeep;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    // effective capacity and the fill kept ahead of an insert
    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CW'(1);
        end else if (32'(r_capacity) > 32'(MAX_ENTRIES)) begin
            w_cap = MAX_CNT;
        end else begin
            w_cap = CW'(r_capacity);
        end
        w_fkeep = (r_fill >= w_cap) ? (w_cap - CW'(1)) : r_fill;
    end

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_is_set   = (i_opcode == OP_SET);
    assign w_hit      = |w_match;
    assign w_insert   = w_acc && w_is_set && !w_hit;

    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_hit_val = w_hit_val | (w_match[i] ? w_val[i] : '0);
        end
    end

    assign w_front_val = w_is_set ? i_value : w_hit_val;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_row
        assign w_le[g] = |w_match[MAX_ENTRIES-1:g];

        always_comb begin
            w_ctl[g].shift     = w_acc && (w_hit ? w_le[g]
                                                 : (w_is_set && (CW'(g) <= w_fkeep)));
            w_ctl[g].valid_we  = w_insert;
            w_ctl[g].valid_nxt = (CW'(g) <= w_fkeep);
        end

        if (g == 0) begin : g_head
            lkvc_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[g]),
                .i_key      (i_key),
                .i_prev_key (i_key),
                .i_prev_val (w_front_val),
                .o_key      (w_key[g]),
                .o_val      (w_val[g]),
                .o_valid    (w_valid[g]),
                .o_match    (w_match[g])
            );
        end else begin : g_body
            lkvc_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl[g]),
                .i_key      (i_key),
                .i_prev_key (w_key[g-1]),
                .i_prev_val (w_val[g-1]),
                .o_key      (w_key[g]),
                .o_val      (w_val[g]),
                .o_valid    (w_valid[g]),
                .o_match    (w_match[g])
            );
        end
    end

    always_comb begin
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        n_hit       = r_hit;
        n_value_out = r_value_out;
        if (w_insert) begin
            n_fill = w_fkeep + CW'(1);
        end
        if (w_acc && !w_is_set) begin
            n_out_valid = 1'b1;
            n_hit       = w_hit;
            n_value_out = w_hit ? {1'b0, w_hit_val} : '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit       <= n_hit;
        r_value_out <= n_value_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_hit       = r_hit;
    assign o_value_out = r_value_out;

`ifndef SYNTH
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matches the key");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= MAX_CNT) && ($countones(w_valid) == 32'(r_fill)))
        else $error("valid cells disagree with fill count");

    a_get_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !w_is_set) |=> o_out_valid)
        else $error("get beat produced no result");

    a_set_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_set) |=> (o_out_valid == $past(r_out_valid && i_out_stall)))
        else $error("set beat changed the result register");
`endif

endmodule

// ===== dv/lru_key_value_cache_checker.sv =====
// checker for the lru key-value cache: predicts every get and compares the result beats
// depends on lkvc_pkg; watches the config, request and result channels of the block
module lru_key_value_cache_checker #(
    parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = lkvc_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS  = lkvc_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [lkvc_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_opcode,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [VALUE_BITS-1:0]        i_value,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_hit,
    input  logic signed [VALUE_BITS:0]   i_value_out,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    typedef struct packed {
        logic                       hit;
        logic signed [VALUE_BITS:0] value_out;
    } t_lookup;

    t_lookup               lookup_q[$];
    logic [KEY_BITS-1:0]   ent_key[MAX_ENTRIES];
    logic [VALUE_BITS-1:0] ent_val[MAX_ENTRIES];
    int                    fill_cnt;
    logic [CAP_W-1:0]      cap_reg;

    task automatic move_front(input int pos);
        logic [KEY_BITS-1:0]   k;
        logic [VALUE_BITS-1:0] v;
        k = ent_key[pos];
        v = ent_val[pos];
        for (int i = pos; i > 0; i--) begin
            ent_key[i] = ent_key[i-1];
            ent_val[i] = ent_val[i-1];
        end
        ent_key[0] = k;
        ent_val[0] = v;
    endtask

    task automatic apply_request(input logic op, input logic [KEY_BITS-1:0] k,
                                 input logic [VALUE_BITS-1:0] v);
        int      pos;
        int      lim;
        t_lookup res;
        pos = fill_cnt;
        for (int i = 0; i < fill_cnt; i++) begin
            if (pos == fill_cnt && ent_key[i] == k) pos = i;
        end
        if (op == OP_GET) begin
            if (pos < fill_cnt) begin
                res.hit       = 1'b1;
                res.value_out = {1'b0, ent_val[pos]};
                move_front(pos);
            end else begin
                res.hit       = 1'b0;
                res.value_out = '1;
            end
            lookup_q.push_back(res);
        end else if (pos < fill_cnt) begin
            ent_val[pos] = v;
            move_front(pos);
        end else begin
            lim = (cap_reg == 0) ? 1 : ((cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap_reg));
            if (fill_cnt >= lim) fill_cnt = lim - 1;
            for (int i = fill_cnt; i > 0; i--) begin
                ent_key[i] = ent_key[i-1];
                ent_val[i] = ent_val[i-1];
            end
            ent_key[0] = k;
            ent_val[0] = v;
            fill_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lookup e;
        if (!i_rst_n) begin
            lookup_q.delete();
            fill_cnt     = 0;
            cap_reg      = CAP_RESET;
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) cap_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) apply_request(i_opcode, i_key, i_value);
            if (i_out_valid && !i_out_stall) begin
                if (lookup_q.size() == 0) begin
                    $error("value_out: beat with no lookup pending, actual %0d", i_value_out);
                    o_fail_count++;
                end else begin
                    e = lookup_q.pop_front();
                    if (i_hit !== e.hit) begin
                        $error("hit: expected %0b, actual %0b", e.hit, i_hit);
                        o_fail_count++;
                    end
                    if (i_value_out !== e.value_out) begin
                        $error("value_out: expected %0d, actual %0d", e.value_out, i_value_out);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = lookup_q.size();
    end

endmodule

// ===== dv/tb_lru_key_value_cache_top.sv =====
// testbench top for the lru key-value cache: clock, reset, requests, config and verdict
// depends on lkvc_pkg, lru_key_value_cache_top and lru_key_value_cache_checker
module tb_lru_key_value_cache_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int NKEYS      = 24;
    localparam int HOLD_LEN   = 200;
    localparam int HOLD_EVERY = 2500;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_opcode;
    logic [15:0]          i_key;
    logic [15:0]          i_value;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_hit;
    logic signed [16:0]   o_value_out;

    int                   fail_count;
    int                   pending;
    bit                   burst;
    int                   cap_eff;
    logic [15:0]          key_pool[NKEYS];
    logic [CAP_W-1:0]     phase_cap[10];

    always #6 i_clk = ~i_clk;

    lru_key_value_cache_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hit       (o_hit),
        .o_value_out (o_value_out)
    );

    lru_key_value_cache_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_hit        (o_hit),
        .i_value_out  (o_value_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_key();
        int span;
        span = (cap_eff + 4 > NKEYS) ? NKEYS : cap_eff + 4;
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return key_pool[$urandom_range(0, span - 1)];
    endfunction

    task automatic send_request(input logic op, input logic [15:0] k, input logic [15:0] v);
        int gap;
        gap = idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_opcode   = op;
        i_key      = k;
        i_value    = v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic get_key(input logic [15:0] k);
        send_request(OP_GET, k, 16'($urandom));
    endtask

    task automatic set_key(input logic [15:0] k, input logic [15:0] v);
        send_request(OP_SET, k, v);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_data  = c;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cap_eff = (c == 0) ? 1 : ((c > 16) ? 16 : int'(c));
    endtask

    // result side: random stall runs, free-flowing stretches and periodic long hold-offs
    initial begin : rx_side
        int cyc;
        int next_hold;
        int len;
        int r;
        i_out_stall = 1'b0;
        cyc         = 0;
        next_hold   = 300;
        @(negedge i_clk);
        forever begin
            if (cyc >= next_hold) begin
                i_out_stall = 1'b1;
                len         = HOLD_LEN;
                next_hold   = next_hold + HOLD_EVERY;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    i_out_stall = 1'b0;
                    len         = $urandom_range(20, 80);
                end else if (r < 90) begin
                    i_out_stall = 1'($urandom_range(0, 1));
                    len         = $urandom_range(1, 3);
                end else begin
                    i_out_stall = 1'b1;
                    len         = $urandom_range(5, 40);
                end
            end
            repeat (len) @(negedge i_clk);
            cyc = cyc + len;
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_opcode    = OP_GET;
        i_key       = '0;
        i_value     = '0;
        burst       = 1'b0;
        cap_eff     = 16;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hffff;
        for (int i = 2; i < NKEYS; i++) key_pool[i] = 16'($urandom);
        phase_cap[0] = 5'd1;
        phase_cap[1] = 5'd16;
        phase_cap[2] = 5'd2;
        phase_cap[3] = 5'd0;
        phase_cap[4] = 5'($urandom_range(3, 15));
        phase_cap[5] = 5'd31;
        phase_cap[6] = 5'($urandom_range(17, 30));
        phase_cap[7] = 5'd4;
        phase_cap[8] = 5'd16;
        phase_cap[9] = 5'd8;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty store, key extremes, value extremes, update in place
        get_key(16'h0000);
        get_key(16'hffff);
        set_key(16'h0000, 16'hffff);
        set_key(16'hffff, 16'h0000);
        get_key(16'h0000);
        get_key(16'hffff);
        set_key(16'h0000, 16'h1234);
        get_key(16'h0000);
        set_key(16'd1, 16'h5555);
        set_key(16'd2, 16'haaaa);
        set_key(16'd3, 16'h0f0f);
        set_key(16'd4, 16'hf0f0);

        // capacity zero acts as one; held entries survive until the next insert
        write_capacity(5'd0);
        get_key(16'd3);
        set_key(16'd3, 16'h7777);
        get_key(16'd1);
        set_key(16'd7, 16'h8001);
        get_key(16'd1);
        get_key(16'd7);

        // above the entry count saturates
        write_capacity(5'd31);
        for (int i = 0; i < 18; i++) set_key(16'(100 + i), 16'($urandom));
        get_key(16'd100);
        get_key(16'd102);
        get_key(16'd117);

        for (int ph = 0; ph < 10; ph++) begin
            write_capacity(phase_cap[ph]);
            burst = (ph % 3 == 1);
            for (int n = 0; n < 100; n++) begin
                if ($urandom_range(0, 1)) set_key(pick_key(), 16'($urandom));
                else get_key(pick_key());
            end
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
